@@ hdl/ccbsd_pkg.sv @@
package ccbsd_pkg;

    localparam int CCBSD_RAM_BYTES = 2048;

    typedef enum logic [1:0] {
        ACT_READ     = 2'd0,
        ACT_WRITE    = 2'd1,
        ACT_DMA_TICK = 2'd2,
        ACT_DMA_FILL = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        TGT_NONE   = 3'd0,
        TGT_RAM    = 3'd1,
        TGT_VIDEO  = 3'd2,
        TGT_SOUND  = 3'd3,
        TGT_CART   = 3'd4,
        TGT_PAD    = 3'd5,
        TGT_DMAREG = 3'd6,
        TGT_SPRITE = 3'd7
    } t_target;

    localparam logic [15:0] ADDR_RAM_END   = 16'h1FFF;
    localparam logic [15:0] ADDR_VIDEO_END = 16'h3FFF;
    localparam logic [15:0] VIDEO_MASK     = 16'h2007;
    localparam logic [15:0] ADDR_SND_LAST  = 16'h4013;
    localparam logic [15:0] ADDR_DMA_PAGE  = 16'h4014;
    localparam logic [15:0] ADDR_SND_STAT  = 16'h4015;
    localparam logic [15:0] ADDR_PAD_ONE   = 16'h4016;
    localparam logic [15:0] ADDR_PAD_TWO   = 16'h4017;
    localparam logic [15:0] ADDR_CART      = 16'h4020;
    localparam logic [7:0]  PAD_LEFT_RIGHT = 8'h03;
    localparam logic [7:0]  PAD_UP_DOWN    = 8'h0C;

    typedef struct packed {
        t_action     action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        cycle_odd;
        logic [7:0]  pad_one;
        logic [7:0]  pad_two;
    } t_in_item;

    typedef struct packed {
        t_target     target;
        logic        is_write;
        logic [15:0] fwd_address;
        logic [7:0]  fwd_data;
        logic [7:0]  read_data;
        logic        read_external;
        logic        dma_busy;
        logic        unmapped;
    } t_out_item;

    function automatic logic [7:0] fix_pad(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if ((r & PAD_LEFT_RIGHT) == PAD_LEFT_RIGHT) r = r & ~PAD_LEFT_RIGHT;
        if ((r & PAD_UP_DOWN) == PAD_UP_DOWN) r = r & ~PAD_UP_DOWN;
        return r;
    endfunction

endpackage

@@ hdl/ccbsd_chan_if.sv @@
interface ccbsd_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/ccbsd_ram.sv @@
module ccbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/console_cpu_bus_with_sprite_dma.sv @@
// Channel   Direction  Payload      Transfer when
// i_in      in         t_in_item    i_in.valid && i_in.ready
// o_out     out        t_out_item   o_out.valid && o_out.ready
//
// One transfer per cycle is accepted while i_in.ready is high; a result passes
// through the pipeline register, which takes the registered work RAM read,
// and then the output register. After reset the work RAM is cleared one byte
// per cycle, all RAM_BYTES bytes, and i_in.ready stays low until that is done.
// A stalled output holds the pipeline; input stalls just leave bubbles.
module console_cpu_bus_with_sprite_dma #(
    parameter int RAM_BYTES = ccbsd_pkg::CCBSD_RAM_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ccbsd_chan_if.sink          i_in,
    ccbsd_chan_if.source        o_out
);
    import ccbsd_pkg::*;

    localparam int AW = $clog2(RAM_BYTES);

    t_in_item  in_item;
    t_out_item a_item;
    t_out_item p_item;
    t_out_item r_p_item;
    t_out_item r_o_item;
    logic      r_p_valid;
    logic      r_p_use_ram;
    logic      r_p_dma_ram;
    logic      r_o_valid;

    logic [7:0] r_pad_one;
    logic [7:0] r_pad_two;
    logic       r_strobe;
    logic [7:0] r_page;
    logic       r_pend;
    logic       r_run;
    logic [7:0] r_offset;
    logic [7:0] r_dma_byte;
    logic [7:0] n_pad_one;
    logic [7:0] n_pad_two;
    logic       n_strobe;
    logic [7:0] n_page;
    logic       n_pend;
    logic       n_run;
    logic [7:0] n_offset;

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic [15:0]   a_addr;
    logic [16:0]   mod_val;
    logic [AW-1:0] ram_idx;
    logic          a_read;
    logic          a_dma_load;
    logic          a_use_ram;
    logic          a_dma_ram;
    logic          a_dma_set;
    logic [7:0]    a_dma_val;
    logic          a_ram_we;
    logic [7:0]    dma_byte_now;
    logic [7:0]    pad_sel;

    logic          in_fire;
    logic          p_adv;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign in_item = i_in.data;
    assign p_adv   = r_p_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_clearing && (!r_p_valid || p_adv);
    assign in_fire = i_in.valid && i_in.ready;

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_item;

    assign a_addr = (in_item.action == ACT_DMA_TICK) ? {r_page, r_offset} : in_item.address;

    always_comb begin
        mod_val = {4'd0, a_addr[12:0]};
        for (int k = 2; k >= 0; k--) begin
            if (mod_val >= 17'(RAM_BYTES << k)) begin
                mod_val = mod_val - 17'(RAM_BYTES << k);
            end
        end
        ram_idx = mod_val[AW-1:0];
    end

    assign dma_byte_now = (r_p_valid && r_p_dma_ram) ? ram_rdata : r_dma_byte;

    always_comb begin
        a_item     = '0;
        a_read     = 1'b0;
        a_dma_load = 1'b0;
        a_use_ram  = 1'b0;
        a_dma_ram  = 1'b0;
        a_dma_set  = 1'b0;
        a_dma_val  = r_dma_byte;
        a_ram_we   = 1'b0;
        pad_sel    = '0;
        n_pad_one  = r_pad_one;
        n_pad_two  = r_pad_two;
        n_strobe   = r_strobe;
        n_page     = r_page;
        n_pend     = r_pend;
        n_run      = r_run;
        n_offset   = r_offset;

        case (in_item.action)
            ACT_READ: begin
                a_read = 1'b1;
            end
            ACT_WRITE: begin
                a_item.is_write = 1'b1;
                a_item.fwd_data = in_item.write_data;
                if (a_addr <= ADDR_RAM_END) begin
                    a_ram_we           = 1'b1;
                    a_item.target      = TGT_RAM;
                    a_item.fwd_address = 16'(ram_idx);
                end else if (a_addr <= ADDR_VIDEO_END) begin
                    a_item.target      = TGT_VIDEO;
                    a_item.fwd_address = a_addr & VIDEO_MASK;
                end else if (a_addr <= ADDR_SND_LAST || a_addr == ADDR_SND_STAT
                             || a_addr == ADDR_PAD_TWO) begin
                    a_item.target      = TGT_SOUND;
                    a_item.fwd_address = a_addr;
                end else if (a_addr == ADDR_DMA_PAGE) begin
                    n_page          = in_item.write_data;
                    n_pend          = 1'b1;
                    a_item.target   = TGT_DMAREG;
                    a_item.is_write = 1'b0;
                    a_item.fwd_data = '0;
                end else if (a_addr == ADDR_PAD_ONE) begin
                    n_strobe = in_item.write_data[0];
                    if (in_item.write_data[0]) begin
                        n_pad_one = fix_pad(in_item.pad_one);
                        n_pad_two = fix_pad(in_item.pad_two);
                    end
                    a_item.target   = TGT_PAD;
                    a_item.is_write = 1'b0;
                    a_item.fwd_data = '0;
                end else if (a_addr >= ADDR_CART) begin
                    a_item.target      = TGT_CART;
                    a_item.fwd_address = a_addr;
                end else begin
                    a_item.is_write = 1'b0;
                    a_item.fwd_data = '0;
                    a_item.unmapped = 1'b1;
                end
            end
            ACT_DMA_TICK: begin
                if (r_pend) begin
                    a_item.dma_busy = 1'b1;
                    if (!r_run) begin
                        if (in_item.cycle_odd) begin
                            n_run = 1'b1;
                        end
                    end else if (in_item.cycle_odd) begin
                        a_item.target      = TGT_SPRITE;
                        a_item.is_write    = 1'b1;
                        a_item.fwd_address = {8'd0, r_offset};
                        a_item.fwd_data    = dma_byte_now;
                        n_offset           = r_offset + 8'd1;
                        if (r_offset == 8'hFF) begin
                            n_pend = 1'b0;
                            n_run  = 1'b0;
                        end
                    end else begin
                        a_read     = 1'b1;
                        a_dma_load = 1'b1;
                    end
                end
            end
            ACT_DMA_FILL: begin
                a_dma_set = 1'b1;
                a_dma_val = in_item.write_data;
            end
        endcase

        if (a_read) begin
            if (a_addr <= ADDR_RAM_END) begin
                a_use_ram          = 1'b1;
                a_item.target      = TGT_RAM;
                a_item.fwd_address = 16'(ram_idx);
            end else if (a_addr <= ADDR_VIDEO_END) begin
                a_item.target        = TGT_VIDEO;
                a_item.fwd_address   = a_addr & VIDEO_MASK;
                a_item.read_external = 1'b1;
            end else if (a_addr == ADDR_SND_STAT) begin
                a_item.target        = TGT_SOUND;
                a_item.fwd_address   = a_addr;
                a_item.read_external = 1'b1;
            end else if (a_addr == ADDR_PAD_ONE || a_addr == ADDR_PAD_TWO) begin
                if (r_strobe) begin
                    n_pad_one = fix_pad(in_item.pad_one);
                    n_pad_two = fix_pad(in_item.pad_two);
                end
                a_item.target      = TGT_PAD;
                a_item.fwd_address = a_addr;
                if (a_addr == ADDR_PAD_ONE) begin
                    pad_sel   = n_pad_one;
                    n_pad_one = {pad_sel[6:0], 1'b1};
                end else begin
                    pad_sel   = n_pad_two;
                    n_pad_two = {pad_sel[6:0], 1'b1};
                end
                a_item.read_data = {7'd0, pad_sel[7]};
            end else if (a_addr >= ADDR_CART) begin
                a_item.target        = TGT_CART;
                a_item.fwd_address   = a_addr;
                a_item.read_external = 1'b1;
            end else begin
                a_item.unmapped = 1'b1;
            end
        end

        if (a_dma_load && !a_item.read_external) begin
            if (a_use_ram) begin
                a_dma_ram = 1'b1;
            end else begin
                a_dma_set = 1'b1;
                a_dma_val = a_item.read_data;
            end
        end
    end

    assign ram_we    = r_clearing || (in_fire && a_ram_we);
    assign ram_waddr = r_clearing ? r_clr_addr : ram_idx;
    assign ram_wdata = r_clearing ? 8'd0 : in_item.write_data;

    ccbsd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire && a_use_ram),
        .i_raddr (ram_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(RAM_BYTES - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_one  <= '0;
            r_pad_two  <= '0;
            r_strobe   <= 1'b0;
            r_page     <= '0;
            r_pend     <= 1'b0;
            r_run      <= 1'b0;
            r_offset   <= '0;
            r_dma_byte <= '0;
        end else begin
            if (in_fire) begin
                r_pad_one <= n_pad_one;
                r_pad_two <= n_pad_two;
                r_strobe  <= n_strobe;
                r_page    <= n_page;
                r_pend    <= n_pend;
                r_run     <= n_run;
                r_offset  <= n_offset;
            end
            if (in_fire && a_dma_set) begin
                r_dma_byte <= a_dma_val;
            end else if (p_adv && r_p_dma_ram) begin
                r_dma_byte <= ram_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_p_use_ram <= 1'b0;
            r_p_dma_ram <= 1'b0;
        end else if (in_fire) begin
            r_p_valid   <= 1'b1;
            r_p_use_ram <= a_use_ram;
            r_p_dma_ram <= a_dma_ram;
        end else if (p_adv) begin
            r_p_valid   <= 1'b0;
            r_p_dma_ram <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_p_item <= a_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_comb begin
        p_item = r_p_item;
        if (r_p_use_ram) begin
            p_item.read_data = ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_o_item <= p_item;
        end
    end
endmodule
